[hdl/cell_merge_fold_core_defines.svh]
// Assertion macros shared by the cell merge fold RTL
`ifndef CELL_MERGE_FOLD_CORE_DEFINES_SVH
`define CELL_MERGE_FOLD_CORE_DEFINES_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is asserted
`define CMF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define CMF_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMF_ASSERT(lbl, clk, rst_n, prop, msg)
`define CMF_ASSERT_ANY(lbl, clk, prop, msg)
`endif

`endif

[hdl/cmf_pkg.sv]
package cmf_pkg;

  localparam int unsigned PolicyW = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdentW  = 16;

  // merge rules; codes 6 and 7 behave as latest
  typedef enum logic [PolicyW-1:0] {
    POL_LATEST  = 3'd0,
    POL_OLDEST  = 3'd1,
    POL_AND     = 3'd2,
    POL_OR      = 3'd3,
    POL_XOR     = 3'd4,
    POL_AVERAGE = 3'd5
  } policy_e;

  // one candidate cell, as kept in the accumulator
  typedef struct packed {
    logic [ByteW-1:0]  alpha;
    logic [ByteW-1:0]  blue;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  red;
    logic [ByteW-1:0]  energy;
    logic [ByteW-1:0]  mode;
    logic [IdentW-1:0] ident;
  } cell_t;

  // input word
  typedef struct packed {
    logic [ByteW-1:0]  alpha;
    logic [ByteW-1:0]  blue;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  red;
    logic [ByteW-1:0]  energy;
    logic [ByteW-1:0]  cell_mode;
    logic [IdentW-1:0] ident;
    logic              first;
    logic              last;
    logic              empty_set;
  } cell_in_t;

  // result word
  typedef struct packed {
    logic [ByteW-1:0]  out_alpha;
    logic [ByteW-1:0]  out_blue;
    logic [ByteW-1:0]  out_green;
    logic [ByteW-1:0]  out_red;
    logic [ByteW-1:0]  out_energy;
    logic [ByteW-1:0]  out_mode;
    logic [IdentW-1:0] out_ident;
  } cell_out_t;

  // floor average of two bytes
  function automatic logic [ByteW-1:0] avg8(logic [ByteW-1:0] a, logic [ByteW-1:0] b);
    logic [ByteW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[ByteW:1];
  endfunction

  // floor average of two identifiers
  function automatic logic [IdentW-1:0] avg16(logic [IdentW-1:0] a, logic [IdentW-1:0] b);
    logic [IdentW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[IdentW:1];
  endfunction

endpackage

[hdl/cell_merge_fold_core.sv]
// Flow: a word accepted into the input register is merged from there into the
//   accumulator, and its result (if it ends a set) is loaded into the output register.
// Throughput: one word per cycle while no result waits on a full output register;
//   the merge is one pass of per-field logic between the input register and the accumulator/result registers.
// Reset (rst_ni low, asynchronous): clears the valid flags, the accumulator and the
//   merge policy (latest).
`include "cell_merge_fold_core_defines.svh"

module cell_merge_fold_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // candidate channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cmf_pkg::cell_in_t              in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cmf_pkg::cell_out_t             out_data_o,
  // policy register write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cmf_pkg::PolicyW-1:0]    cfg_data_i
);

  cmf_pkg::policy_e   policy_q;
  logic               s1_valid_q;
  cmf_pkg::cell_in_t  s1_q;
  cmf_pkg::cell_t     acc_q, acc_d;
  cmf_pkg::cell_t     s1_cell, merged;
  logic               out_valid_q, out_valid_d;
  cmf_pkg::cell_out_t out_data_q, out_data_d;
  logic               emits, out_free, s1_adv, out_load, acc_load;

  // policy register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= cmf_pkg::POL_LATEST;
    end else if (cfg_valid_i) begin
      policy_q <= cmf_pkg::policy_e'(cfg_data_i);
    end
  end

  // handshake between input register and result register
  assign emits      = s1_q.last | s1_q.empty_set;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign s1_adv     = s1_valid_q & (out_free | ~emits);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign out_load   = s1_adv & emits;
  assign acc_load   = s1_adv & ~s1_q.empty_set;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
  end

  // merge of the registered word into the accumulator
  always_comb begin
    s1_cell.alpha  = s1_q.alpha;
    s1_cell.blue   = s1_q.blue;
    s1_cell.green  = s1_q.green;
    s1_cell.red    = s1_q.red;
    s1_cell.energy = s1_q.energy;
    s1_cell.mode   = s1_q.cell_mode;
    s1_cell.ident  = s1_q.ident;
  end

  cmf_merge u_merge (
    .older_i  (acc_q),
    .newer_i  (s1_cell),
    .policy_i (policy_q),
    .merged_o (merged)
  );

  assign acc_d = s1_q.first ? s1_cell : merged;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (acc_load) begin
      acc_q <= acc_d;
    end
  end

  // result register; an empty set gives the zero cell
  always_comb begin
    if (s1_q.empty_set) begin
      out_data_d = '0;
    end else begin
      out_data_d.out_alpha  = acc_d.alpha;
      out_data_d.out_blue   = acc_d.blue;
      out_data_d.out_green  = acc_d.green;
      out_data_d.out_red    = acc_d.red;
      out_data_d.out_energy = acc_d.energy;
      out_data_d.out_mode   = acc_d.mode;
      out_data_d.out_ident  = acc_d.ident;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `CMF_ASSERT(a_nonemit_never_stalls, clk_i, rst_ni, (s1_valid_q && !emits) |-> s1_adv, "word without result stalled")
  `CMF_ASSERT(a_empty_gives_zero, clk_i, rst_ni, (s1_adv && s1_q.empty_set) |=> (out_valid_q && out_data_q == '0), "empty set result not zero")
  `CMF_ASSERT(a_empty_keeps_acc, clk_i, rst_ni, (s1_adv && s1_q.empty_set) |=> $stable(acc_q), "empty set changed accumulator")
  `CMF_ASSERT(a_first_loads_cell, clk_i, rst_ni, (s1_adv && s1_q.first && !s1_q.empty_set) |=> (acc_q == $past(s1_cell)), "first word did not load accumulator")
  `CMF_ASSERT_ANY(a_idle_input_ready, clk_i, !s1_valid_q |-> in_ready_o, "input stalled while input register empty")

endmodule

[hdl/cmf_merge.sv]
// Pairwise cell merge: older is the accumulator, newer the incoming cell
module cmf_merge (
  input  cmf_pkg::cell_t   older_i,
  input  cmf_pkg::cell_t   newer_i,
  input  cmf_pkg::policy_e policy_i,
  output cmf_pkg::cell_t   merged_o
);

  always_comb begin
    merged_o = newer_i;
    unique case (policy_i)
      cmf_pkg::POL_OLDEST: begin
        merged_o = older_i;
      end
      cmf_pkg::POL_AND: begin
        merged_o = older_i & newer_i;
      end
      cmf_pkg::POL_OR: begin
        merged_o = older_i | newer_i;
        // mode takes the larger value
        merged_o.mode = (older_i.mode > newer_i.mode) ? older_i.mode : newer_i.mode;
      end
      cmf_pkg::POL_XOR: begin
        merged_o = older_i ^ newer_i;
        merged_o.mode = '0;
      end
      cmf_pkg::POL_AVERAGE: begin
        merged_o.alpha  = cmf_pkg::avg8(older_i.alpha, newer_i.alpha);
        merged_o.blue   = cmf_pkg::avg8(older_i.blue, newer_i.blue);
        merged_o.green  = cmf_pkg::avg8(older_i.green, newer_i.green);
        merged_o.red    = cmf_pkg::avg8(older_i.red, newer_i.red);
        merged_o.energy = cmf_pkg::avg8(older_i.energy, newer_i.energy);
        merged_o.mode   = older_i.mode;
        merged_o.ident  = cmf_pkg::avg16(older_i.ident, newer_i.ident);
      end
      default: begin
        // latest, and the unused codes
        merged_o = newer_i;
      end
    endcase
  end

endmodule
